FILE: rtl/clre_pkg.sv
// Shared types and constants of the carryless range encoder.
`default_nettype none

package clre_pkg;

	localparam logic [31:0] RANGE_TOP = 32'h0100_0000;
	localparam logic [31:0] RANGE_BOT = 32'h0001_0000;
	localparam logic [2:0]  MAX_BYTES = 3'd4;
	localparam logic [3:0]  DIV_LAST  = 4'd15;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_DIV,
		ST_MUL_C,
		ST_MUL_F,
		ST_LOAD,
		ST_CHECK,
		ST_LOOK,
		ST_SEND,
		ST_FLUSH
	} enc_state_t;

	typedef struct packed {
		logic        start;
		logic [31:0] dividend;
		logic [15:0] divisor;
	} div_req_t;

	typedef struct packed {
		logic        done;
		logic [31:0] quotient;
	} div_rsp_t;

endpackage

`default_nettype wire

FILE: rtl/clre_in_if.sv
// Symbol channel of the encoder: valid, ready and one encode or flush item.
`default_nettype none

interface clre_in_if;
	logic        valid;
	logic        ready;
	logic        mode;
	logic [15:0] cum_count;
	logic [15:0] freq_count;
	logic [15:0] total_count;

	modport source (output valid, mode, cum_count, freq_count, total_count, input ready);
	modport sink   (input valid, mode, cum_count, freq_count, total_count, output ready);
endinterface

`default_nettype wire

FILE: rtl/clre_out_if.sv
// Byte channel of the encoder: valid, ready and one stream byte.
`default_nettype none

interface clre_out_if;
	logic       valid;
	logic       ready;
	logic [7:0] out_byte;
	logic       last_byte;

	modport source (output valid, out_byte, last_byte, input ready);
	modport sink   (input valid, out_byte, last_byte, output ready);
endinterface

`default_nettype wire

FILE: rtl/clre_div.sv
// Iterative 32-by-16 restoring divider, two quotient bits per cycle.
`default_nettype none

module clre_div (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire clre_pkg::div_req_t req,
	output clre_pkg::div_rsp_t      rsp
);

	logic        busy_q;
	logic        done_q;
	logic [3:0]  cnt_q;
	logic [31:0] dq_q;
	logic [15:0] rem_q;
	logic [15:0] dvs_q;

	logic [16:0] r1, r2, d1, d2;
	logic        ge1, ge2;
	logic [15:0] rem1, rem2;
	logic [31:0] dq1, dq2;

	always_comb begin
		r1   = {rem_q, dq_q[31]};
		ge1  = r1 >= {1'b0, dvs_q};
		d1   = r1 - {1'b0, dvs_q};
		rem1 = ge1 ? d1[15:0] : r1[15:0];
		dq1  = {dq_q[30:0], ge1};
		r2   = {rem1, dq1[31]};
		ge2  = r2 >= {1'b0, dvs_q};
		d2   = r2 - {1'b0, dvs_q};
		rem2 = ge2 ? d2[15:0] : r2[15:0];
		dq2  = {dq1[30:0], ge2};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 4'd1;
				if (cnt_q == clre_pkg::DIV_LAST) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			dq_q  <= req.dividend;
			rem_q <= '0;
			dvs_q <= req.divisor;
		end else if (busy_q) begin
			dq_q  <= dq2;
			rem_q <= rem2;
		end
	end

	assign rsp.done     = done_q;
	assign rsp.quotient = dq_q;

endmodule

`default_nettype wire

FILE: rtl/carryless_range_encoder.sv
// Top level of the carryless range encoder: sequencer, shared multiplier, renormaliser.
// Encode: accept the item, divide in the two-bit-per-cycle divider, multiply twice in the shared
// 32x16 multiplier, then a range check alone or a check, look and send per emitted byte plus stalls.
// An encode item emits up to four bytes; a flush sends four bytes, each through FLUSH and SEND.
// One item at a time: symbol.ready is high only while the sequencer is idle.
// Reset (arst_n, asynchronous) gives low 0 and range all ones, no pending bytes.
`default_nettype none

module carryless_range_encoder (
	input  wire logic   clk,
	input  wire logic   arst_n,
	clre_in_if.sink     symbol,
	clre_out_if.source  stream
);

	clre_pkg::enc_state_t state_q, state_d;
	clre_pkg::div_req_t   div_req;
	clre_pkg::div_rsp_t   div_rsp;

	logic [31:0] low_q;
	logic [31:0] range_q;
	logic [31:0] prod_q;
	logic [15:0] cum_q;
	logic [15:0] frq_q;
	logic [2:0]  cnt_q;
	logic        flush_q;
	logic [7:0]  byte_q;
	logic        last_q;

	logic        in_acc;
	logic        out_acc;
	logic [15:0] mul_b;
	logic [47:0] mul_p;
	logic [31:0] sum;
	logic        agree;
	logic        narrow;
	logic        emit_ok;
	logic [31:0] clamp;
	logic [31:0] rng_use;

	assign symbol.ready     = (state_q == clre_pkg::ST_IDLE);
	assign stream.valid     = (state_q == clre_pkg::ST_SEND);
	assign stream.out_byte  = byte_q;
	assign stream.last_byte = last_q;

	assign in_acc  = symbol.valid && symbol.ready;
	assign out_acc = stream.valid && stream.ready;

	assign div_req.start    = in_acc && !symbol.mode;
	assign div_req.dividend = range_q;
	assign div_req.divisor  = (symbol.total_count == 16'd0) ? 16'd1 : symbol.total_count;

	clre_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	// shared multiplier: quotient times cum, then quotient times freq
	assign mul_b = (state_q == clre_pkg::ST_MUL_C) ? cum_q : frq_q;
	assign mul_p = range_q * mul_b;

	// renormalisation test on the current interval
	always_comb begin
		sum     = low_q + range_q;
		agree   = (low_q ^ sum) < clre_pkg::RANGE_TOP;
		narrow  = range_q < clre_pkg::RANGE_BOT;
		emit_ok = (cnt_q < clre_pkg::MAX_BYTES) && (agree || narrow);
		clamp   = (32'd0 - low_q) & (clre_pkg::RANGE_BOT - 32'd1);
		rng_use = agree ? range_q : clamp;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= clre_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			clre_pkg::ST_IDLE: begin
				if (in_acc) begin
					state_d = symbol.mode ? clre_pkg::ST_FLUSH : clre_pkg::ST_DIV;
				end
			end
			clre_pkg::ST_DIV: begin
				if (div_rsp.done) begin
					state_d = clre_pkg::ST_MUL_C;
				end
			end
			clre_pkg::ST_MUL_C: state_d = clre_pkg::ST_MUL_F;
			clre_pkg::ST_MUL_F: state_d = clre_pkg::ST_LOAD;
			clre_pkg::ST_LOAD:  state_d = clre_pkg::ST_CHECK;
			clre_pkg::ST_CHECK: begin
				state_d = emit_ok ? clre_pkg::ST_LOOK : clre_pkg::ST_IDLE;
			end
			clre_pkg::ST_LOOK:  state_d = clre_pkg::ST_SEND;
			clre_pkg::ST_FLUSH: state_d = clre_pkg::ST_SEND;
			clre_pkg::ST_SEND: begin
				if (out_acc) begin
					if (last_q) begin
						state_d = clre_pkg::ST_IDLE;
					end else begin
						state_d = flush_q ? clre_pkg::ST_FLUSH : clre_pkg::ST_CHECK;
					end
				end
			end
			default: state_d = clre_pkg::ST_IDLE;
		endcase
	end

	// coder state and sequencer bookkeeping
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			low_q   <= '0;
			range_q <= '1;
			cnt_q   <= '0;
			flush_q <= 1'b0;
		end else begin
			unique case (state_q)
				clre_pkg::ST_IDLE: begin
					if (in_acc) begin
						cnt_q   <= '0;
						flush_q <= symbol.mode;
					end
				end
				clre_pkg::ST_DIV: begin
					if (div_rsp.done) begin
						range_q <= div_rsp.quotient;
					end
				end
				clre_pkg::ST_MUL_F: low_q   <= low_q + prod_q;
				clre_pkg::ST_LOAD:  range_q <= prod_q;
				clre_pkg::ST_CHECK: begin
					if (emit_ok) begin
						low_q   <= low_q << 8;
						range_q <= rng_use << 8;
						cnt_q   <= cnt_q + 3'd1;
					end
				end
				clre_pkg::ST_FLUSH: begin
					cnt_q <= cnt_q + 3'd1;
					if (cnt_q == clre_pkg::MAX_BYTES - 3'd1) begin
						low_q   <= '0;
						range_q <= '1;
					end else begin
						low_q <= low_q << 8;
					end
				end
				default: begin
				end
			endcase
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		unique case (state_q)
			clre_pkg::ST_IDLE: begin
				if (in_acc) begin
					cum_q <= symbol.cum_count;
					frq_q <= symbol.freq_count;
				end
			end
			clre_pkg::ST_MUL_C, clre_pkg::ST_MUL_F: prod_q <= mul_p[31:0];
			clre_pkg::ST_CHECK: begin
				if (emit_ok) begin
					byte_q <= low_q[31:24];
				end
			end
			// last byte of an encode item: no further byte would follow
			clre_pkg::ST_LOOK: last_q <= !emit_ok;
			clre_pkg::ST_FLUSH: begin
				byte_q <= low_q[31:24];
				last_q <= (cnt_q == clre_pkg::MAX_BYTES - 3'd1);
			end
			default: begin
			end
		endcase
	end

endmodule

`default_nettype wire

FILE: test/tb.sv
// Self-checking testbench of the carryless range encoder: directed and random symbol traffic.
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int CYCLE_LIMIT = 200000;
	localparam int PHASE_ITEMS = 48;
	localparam int HOLD_CYCLES = 300;

	localparam logic MODE_ENCODE = 1'b0;
	localparam logic MODE_FLUSH  = 1'b1;

	typedef struct {
		logic [7:0] out_byte;
		logic       last_byte;
	} stream_byte_t;

	// Tracks the coder interval and the stream bytes still owed by the block.
	class byte_scoreboard;
		logic [31:0]  low_q;
		logic [31:0]  range_q;
		stream_byte_t owed[$];
		int           errors;

		function new();
			low_q   = '0;
			range_q = '1;
			errors  = 0;
		endfunction

		function void push_top(logic last);
			stream_byte_t b;
			b.out_byte  = low_q[31:24];
			b.last_byte = last;
			owed.push_back(b);
		endfunction

		function void note_symbol(logic mode, logic [15:0] cum, logic [15:0] freq,
				logic [15:0] total);
			logic [31:0] divisor;
			int          sent;
			if (mode == MODE_FLUSH) begin
				for (int k = 0; k < 4; k++) begin
					push_top(k == 3);
					low_q = low_q << 8;
				end
				low_q   = '0;
				range_q = '1;
				return;
			end
			divisor = (total == 16'd0) ? 32'd1 : {16'd0, total};
			range_q = range_q / divisor;
			low_q   = low_q + {16'd0, cum} * range_q;
			range_q = range_q * {16'd0, freq};
			sent = 0;
			while (sent < int'(clre_pkg::MAX_BYTES)) begin
				if ((low_q ^ (low_q + range_q)) >= clre_pkg::RANGE_TOP) begin
					if (range_q >= clre_pkg::RANGE_BOT)
						break;
					// carry would escape: clamp range up to the next 64k boundary
					range_q = (32'd0 - low_q) & (clre_pkg::RANGE_BOT - 32'd1);
				end
				push_top(1'b0);
				sent++;
				low_q   = low_q << 8;
				range_q = range_q << 8;
			end
			if (sent > 0)
				owed[$].last_byte = 1'b1;
		endfunction

		function void check_byte(logic [7:0] out_byte, logic last_byte);
			stream_byte_t want;
			if (owed.size() == 0) begin
				$display("%0t: unexpected byte: expected none, actual %02h last %0b",
					$time, out_byte, last_byte);
				errors++;
				return;
			end
			want = owed.pop_front();
			if (out_byte !== want.out_byte) begin
				$display("%0t: out_byte mismatch: expected %02h, actual %02h",
					$time, want.out_byte, out_byte);
				errors++;
			end
			if (last_byte !== want.last_byte) begin
				$display("%0t: last_byte mismatch: expected %0b, actual %0b",
					$time, want.last_byte, last_byte);
				errors++;
			end
		endfunction
	endclass

	logic clk;
	logic arst_n;

	clre_in_if  symbol_if ();
	clre_out_if stream_if ();

	carryless_range_encoder i_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.symbol (symbol_if),
		.stream (stream_if)
	);

	byte_scoreboard sb;
	int             idle_pct  = 0;
	int             stall_pct = 0;
	int             hold_left = 0;
	int             cycle_count = 0;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("tb: FAIL");
			$finish;
		end
	end

	// Receiver: random stalls, plus a long hold-off counted down here.
	initial begin
		stream_if.ready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (hold_left > 0) begin
				stream_if.ready = 1'b0;
				hold_left--;
			end else begin
				stream_if.ready = ($urandom_range(99) >= stall_pct);
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n && stream_if.valid && stream_if.ready)
			sb.check_byte(stream_if.out_byte, stream_if.last_byte);
	end

	// Called at a falling edge; returns at the falling edge after the transaction,
	// with valid dropped so that the item is not taken twice.
	task automatic send_symbol(logic mode, logic [15:0] cum, logic [15:0] freq,
			logic [15:0] total);
		while ($urandom_range(99) < idle_pct) begin
			symbol_if.valid = 1'b0;
			@(negedge clk);
		end
		symbol_if.valid       = 1'b1;
		symbol_if.mode        = mode;
		symbol_if.cum_count   = cum;
		symbol_if.freq_count  = freq;
		symbol_if.total_count = total;
		@(posedge clk);
		while (!symbol_if.ready)
			@(posedge clk);
		sb.note_symbol(mode, cum, freq, total);
		@(negedge clk);
		symbol_if.valid = 1'b0;
	endtask

	task automatic send_random_symbol();
		int          pick;
		logic [15:0] total;
		logic [15:0] cum;
		pick = $urandom_range(99);
		if (pick < 7) begin
			send_symbol(MODE_FLUSH, 16'($urandom), 16'($urandom), 16'($urandom));
		end else if (pick < 85) begin
			// well-formed interval: cum + freq within total
			case ($urandom_range(2))
				0: total = 16'($urandom_range(1, 64));
				1: total = 16'($urandom_range(1, 65535));
				default: total = 16'hFFFF;
			endcase
			cum = 16'($urandom_range(0, total - 1));
			send_symbol(MODE_ENCODE, cum, 16'($urandom_range(1, total - cum)), total);
		end else begin
			send_symbol(MODE_ENCODE, 16'($urandom), 16'($urandom), 16'($urandom));
		end
	endtask

	task automatic wait_drained();
		while (sb.owed.size() != 0)
			@(negedge clk);
	endtask

	initial begin
		sb = new();
		arst_n                = 1'b0;
		symbol_if.valid       = 1'b0;
		symbol_if.mode        = MODE_ENCODE;
		symbol_if.cum_count   = '0;
		symbol_if.freq_count  = '0;
		symbol_if.total_count = '0;
		repeat (12) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// no bytes: full interval leaves the range wide
		send_symbol(MODE_ENCODE, 16'd0, 16'd1, 16'd1);
		send_symbol(MODE_FLUSH, 16'd0, 16'd0, 16'd0);
		// zero total and zero frequency: range collapses, renormalisation overruns
		send_symbol(MODE_ENCODE, 16'd0, 16'd0, 16'd0);
		send_symbol(MODE_ENCODE, 16'hFFFF, 16'hFFFF, 16'hFFFF);
		send_symbol(MODE_ENCODE, 16'd0, 16'd1, 16'hFFFF);
		send_symbol(MODE_ENCODE, 16'hFFFE, 16'd1, 16'hFFFF);
		send_symbol(MODE_ENCODE, 16'd0, 16'd0, 16'hFFFF);
		send_symbol(MODE_FLUSH, 16'hFFFF, 16'hFFFF, 16'hFFFF);
		send_symbol(MODE_FLUSH, 16'd0, 16'd0, 16'd0);
		send_symbol(MODE_ENCODE, 16'hFFFF, 16'd1, 16'd0);
		send_symbol(MODE_ENCODE, 16'd1, 16'hFFFF, 16'hFFFF);
		repeat (6) send_symbol(MODE_ENCODE, 16'd12345, 16'd3, 16'd40000);
		send_symbol(MODE_ENCODE, 16'h8000, 16'h7FFF, 16'hFFFF);
		send_symbol(MODE_ENCODE, 16'd1, 16'd1, 16'd3);
		send_symbol(MODE_FLUSH, 16'd0, 16'd0, 16'd0);
		wait_drained();

		for (int phase = 0; phase < 4; phase++) begin
			case (phase)
				0: begin idle_pct = 0;  stall_pct = 0;  end
				1: begin idle_pct = 84; stall_pct = 0;  end
				2: begin idle_pct = 0;  stall_pct = 84; end
				default: begin idle_pct = 7; stall_pct = 7; end
			endcase
			if (phase == 0) begin
				@(posedge clk);
				hold_left = HOLD_CYCLES;
				@(negedge clk);
			end
			for (int n = 0; n < PHASE_ITEMS; n++)
				send_random_symbol();
			symbol_if.valid = 1'b0;
			wait_drained();
		end

		stall_pct = 0;
		repeat (60) @(negedge clk);
		if (sb.errors == 0 && sb.owed.size() == 0)
			$display("tb: PASS");
		else
			$display("tb: FAIL");
		$finish;
	end
endmodule

FILE: carryless_range_encoder.f
rtl/clre_pkg.sv
rtl/clre_in_if.sv
rtl/clre_out_if.sv
rtl/clre_div.sv
rtl/carryless_range_encoder.sv
test/tb.sv
